// File: hdl/ter_pkg.sv
// Package for the triangle edge rasterizer: coordinate widths, stream widths
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ter_pkg;

  localparam int COORD_W   = 16;                  // vertex coordinate, signed fixed point
  localparam int FRAC_BITS = 4;                   // fractional bits of a coordinate
  localparam int PIX_W     = COORD_W - FRAC_BITS; // integer pixel coordinate
  localparam int CUR_W     = PIX_W + 1;           // cursor, may step one past the box
  localparam int DIFF_W    = COORD_W + 1;         // difference of two coordinates
  localparam int PROD_W    = 2 * DIFF_W;          // one edge-function product
  localparam int ACC_W     = PROD_W + 1;          // difference of two products
  localparam int COLOR_W   = 24;

  localparam int NUM_COORDS = 6;
  localparam int STEP_W     = 3;                  // multiply step counter
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(6);

  localparam int IN_DATA_W  = 8 * ((NUM_COORDS * COORD_W + COLOR_W + 7) / 8);
  localparam int OUT_DATA_W = 8 * ((2 * PIX_W + COLOR_W + 7) / 8);

  // Input kind codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_STEP,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: hdl/triangle_edge_rasterizer_core.sv
// Pull-mode edge-function triangle rasterizer, top level.
// Depends on ter_pkg for widths, codes and the sequencer state type.
//
// Usage:
//   The input stream carries one beat per request. in_tuser = 0 starts a
//   triangle: in_tdata holds the three vertices (signed fixed point, 4
//   fractional bits) and a 24-bit color. The bounding box is formed from the
//   min and max coordinates, truncated toward zero. A start gives no result.
//   in_tuser = 1 asks for the next covered pixel. The box is walked x outer,
//   y inner, both ascending; each pixel is tested with the ab, bc and ca edge functions
//   through one shared 17x17 multiplier. Every next request gives exactly one
//   output beat: out_tuser = 1 with the pixel and color, or out_tuser = 0 with
//   zero data once the box is exhausted (or no triangle is loaded).
// Sequencing:
//   A start is taken while the sequencer stays idle. A next tests box pixels in
//   turn up to the first covered one (six multiply steps, one accumulate step,
//   one cursor step each), then loads the output register; a new input is
//   accepted only after the last result is loaded. The single multiplier sets
//   the pace of each test. in_tready is high only while the sequencer is idle.
// Reset and stall:
//   rst_n (synchronous, active low) clears the sequencer, the output valid
//   and the loaded-triangle flag; a next before any start returns found = 0.
//   A stalled output beat holds; a finished result waits in the sequencer
//   until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module triangle_edge_rasterizer_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // in_tdata, from bit 0: vert_ax, vert_ay, vert_bx, vert_by, vert_cx,
  // vert_cy (16 bits each), fill_color (24)
  input  wire  [ter_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: kind
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // out_tdata, from bit 0: pixel_x (12), pixel_y (12), pixel_color (24)
  output logic [ter_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: found
  output logic                            out_tuser
);
  import ter_pkg::*;

  // Round toward zero while dropping the fraction.
  function automatic logic signed [PIX_W-1:0] trunc_int(input logic signed [COORD_W-1:0] v);
    logic signed [DIFF_W-1:0] t;
    t = DIFF_W'(v) + (v[COORD_W-1] ? DIFF_W'((1 << FRAC_BITS) - 1) : DIFF_W'(0));
    return t[FRAC_BITS +: PIX_W];
  endfunction

  function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b,
                                                     input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b,
                                                     input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] vert_r [NUM_COORDS];  // ax, ay, bx, by, cx, cy
  logic [COLOR_W-1:0]        color_r;
  logic signed [PIX_W-1:0]   xmax_r, ymin_r, ymax_r;
  logic signed [CUR_W-1:0]   cur_x_r, cur_y_r;
  logic                      active_r;

  logic [STEP_W-1:0]         step_r;
  logic signed [PROD_W-1:0]  mul_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic [2:0]                neg_r;    // sign of each edge function

  logic                      res_found_r;
  logic signed [PIX_W-1:0]   res_x_r, res_y_r;

  logic                      out_tvalid_r;
  logic                      out_tuser_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;

  // Input unpacking
  logic signed [COORD_W-1:0] in_vert [NUM_COORDS];
  logic [COLOR_W-1:0]        in_color;
  always_comb begin
    for (int i = 0; i < NUM_COORDS; i++) begin
      in_vert[i] = in_tdata[i*COORD_W +: COORD_W];
    end
    in_color = in_tdata[NUM_COORDS*COORD_W +: COLOR_W];
  end

  logic in_fire, out_free, start_fire, next_fire;
  assign in_fire    = in_tvalid && in_tready;
  assign start_fire = in_fire && (in_tuser == KIND_START);
  assign next_fire  = in_fire && (in_tuser == KIND_NEXT);
  assign out_free   = !out_tvalid_r || out_tready;

  // Cursor checks against the box
  logic signed [CUR_W-1:0] xmax_ext, ymax_ext;
  logic cur_in_box, y_last, x_last, hit;
  assign xmax_ext   = CUR_W'(xmax_r);
  assign ymax_ext   = CUR_W'(ymax_r);
  assign cur_in_box = cur_x_r <= xmax_ext;
  assign y_last     = cur_y_r == ymax_ext;
  assign x_last     = cur_x_r == xmax_ext;
  assign hit        = (neg_r[0] == neg_r[1]) && (neg_r[1] == neg_r[2]);

  // Shared multiplier operand selection: edge (u,v) is (a,b), (b,c), (c,a).
  logic [1:0] edge_idx;
  logic signed [COORD_W-1:0] ux, uy, vx, vy, px, py;
  logic signed [DIFF_W-1:0]  op_a, op_b;
  assign edge_idx = step_r[2:1];
  assign px = {cur_x_r[PIX_W-1:0], {FRAC_BITS{1'b0}}};
  assign py = {cur_y_r[PIX_W-1:0], {FRAC_BITS{1'b0}}};

  always_comb begin
    unique case (edge_idx)
      2'd0: begin
        ux = vert_r[0]; uy = vert_r[1]; vx = vert_r[2]; vy = vert_r[3];
      end
      2'd1: begin
        ux = vert_r[2]; uy = vert_r[3]; vx = vert_r[4]; vy = vert_r[5];
      end
      2'd2: begin
        ux = vert_r[4]; uy = vert_r[5]; vx = vert_r[0]; vy = vert_r[1];
      end
      default: begin
        ux = '0; uy = '0; vx = '0; vy = '0;
      end
    endcase
  end

  always_comb begin
    if (!step_r[0]) begin
      op_a = DIFF_W'(px) - DIFF_W'(vx);
      op_b = DIFF_W'(uy) - DIFF_W'(vy);
    end else begin
      op_a = DIFF_W'(ux) - DIFF_W'(vx);
      op_b = DIFF_W'(py) - DIFF_W'(vy);
    end
  end

  // Accumulate the previous step's product: an even step's product is loaded, an odd one is subtracted.
  logic [STEP_W-1:0]       prev_step;
  logic signed [ACC_W-1:0] edge_val;
  assign prev_step = step_r - STEP_W'(1);
  assign edge_val  = ACC_W'(acc_r) - ACC_W'(mul_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (next_fire) begin
          state_nxt = (active_r && cur_in_box) ? S_TEST : S_EMIT;
        end
      end
      S_TEST: begin
        if (step_r == LAST_STEP) state_nxt = S_STEP;
      end
      S_STEP: begin
        state_nxt = (hit || (y_last && x_last)) ? S_EMIT : S_TEST;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  logic emit_load;
  always_comb begin
    in_tready = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_EMIT:  emit_load = out_free;
      default: begin
        in_tready = 1'b0;
        emit_load = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= 1'b0;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (start_fire) begin
        active_r <= 1'b1;
      end else if (next_fire && !(active_r && cur_in_box)) begin
        active_r <= 1'b0;
      end else if (state_r == S_STEP && !hit && y_last && x_last) begin
        active_r <= 1'b0;
      end

      if (state_r == S_TEST && step_r != LAST_STEP) begin
        step_r <= step_r + STEP_W'(1);
      end else begin
        step_r <= '0;
      end

      if (emit_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start_fire) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        vert_r[i] <= in_vert[i];
      end
      color_r <= in_color;
      xmax_r  <= trunc_int(max3(in_vert[0], in_vert[2], in_vert[4]));
      ymin_r  <= trunc_int(min3(in_vert[1], in_vert[3], in_vert[5]));
      ymax_r  <= trunc_int(max3(in_vert[1], in_vert[3], in_vert[5]));
      cur_x_r <= CUR_W'(trunc_int(min3(in_vert[0], in_vert[2], in_vert[4])));
      cur_y_r <= CUR_W'(trunc_int(min3(in_vert[1], in_vert[3], in_vert[5])));
    end

    if (next_fire) begin
      // Preload a finished result; a found pixel overwrites it.
      res_found_r <= 1'b0;
      res_x_r     <= '0;
      res_y_r     <= '0;
    end

    if (state_r == S_TEST) begin
      mul_r <= op_a * op_b;
      if (step_r != '0) begin
        if (!prev_step[0]) begin
          acc_r <= mul_r;
        end else begin
          neg_r[prev_step[2:1]] <= edge_val[ACC_W-1];
        end
      end
    end

    if (state_r == S_STEP) begin
      // Advance y first, wrap to the next column at the box bottom.
      if (y_last) begin
        cur_y_r <= CUR_W'(ymin_r);
        cur_x_r <= cur_x_r + CUR_W'(1);
      end else begin
        cur_y_r <= cur_y_r + CUR_W'(1);
      end
      if (hit) begin
        res_found_r <= 1'b1;
        res_x_r     <= cur_x_r[PIX_W-1:0];
        res_y_r     <= cur_y_r[PIX_W-1:0];
      end
    end

    if (emit_load) begin
      out_tuser_r <= res_found_r;
      out_tdata_r <= {res_found_r ? color_r : COLOR_W'(0), res_y_r, res_x_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    next_fire |=> !in_tready)
    else $error("input accepted while a fetch is in progress");

  a_cursor_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEST |-> (cur_x_r <= xmax_ext) && (cur_y_r <= ymax_ext))
    else $error("pixel test outside the bounding box");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEST |-> step_r <= LAST_STEP)
    else $error("multiply step counter out of range");

  a_finish_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tuser_r |-> out_tdata_r == '0)
    else $error("finish beat carries nonzero data");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> out_tvalid_r)
    else $error("result load did not raise out_tvalid");

endmodule
`default_nettype wire

// File: tb/sv/tb_triangle_edge_rasterizer_core.sv
// Self-checking testbench for triangle_edge_rasterizer_core: directed corner
// triangles, then random triangle walks with random gaps on both streams.
// Depends on ter_pkg and the rasterizer RTL only.
`timescale 1ns / 1ps
module tb_triangle_edge_rasterizer_core;
  import ter_pkg::*;

  localparam int TOTAL_BEATS     = 1150;   // input beats, directed part included
  localparam int QUIET_TAIL      = 150;    // last beats run with no idling
  localparam int WATCHDOG_CYCLES = 200000; // several times the longest box scan
  localparam int DRAIN_CYCLES    = 64;
  localparam int MIN_Q           = -32768;
  localparam int MAX_Q           = 32767;

  // One result beat: found flag, pixel coordinates and color
  typedef struct packed {
    logic               found;
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [COLOR_W-1:0] color;
  } pixel_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct {
    logic                 kind;
    logic [IN_DATA_W-1:0] data;
    bit                   typed;
    pixel_t               want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = KIND_NEXT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  triangle_edge_rasterizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: the loaded triangle, its bounding box and the walk
  // cursor. Coordinates are held as plain ints, already sign-extended.
  // ---------------------------------------------------------------------
  int     tri_x [3];
  int     tri_y [3];
  logic [COLOR_W-1:0] tri_color = '0;
  int     box_x0 = 0, box_x1 = 0, box_y0 = 0, box_y1 = 0;
  int     scan_x = 0, scan_y = 0;
  bit     walk_live = 1'b0;

  pixel_t pending_pixels [$];   // predicted result beats, oldest first
  stim_row_t directed_rows [$];

  int idle_mode = 2;            // 0 = no idling, 3 = heavy idling
  int mismatch_count = 0;
  int beats_sent = 0, starts_sent = 0, fetches_sent = 0;
  int hits_seen = 0, ends_seen = 0;
  int quiet_cycles = 0;
  int ready_left = 0;
  bit ready_level = 1'b1;

  // Fixed point to integer pixel, truncating toward zero on both sides
  function automatic int toward_zero(int q);
    return (q >= 0) ? (q >>> FRAC_BITS) : -((-q) >>> FRAC_BITS);
  endfunction

  // Sign of the edge function of edge (u,v) at a pixel given in fixed point.
  // Operands stay within 17 bits, so 64-bit products are exact.
  function automatic bit edge_negative(longint px, longint py, int u, int v);
    longint ux, uy, vx, vy;
    ux = tri_x[u];
    uy = tri_y[u];
    vx = tri_x[v];
    vy = tri_y[v];
    return ((px - vx) * (uy - vy) - (ux - vx) * (py - vy)) < 0;
  endfunction

  // Covered when the ab, bc and ca edges agree, which accepts either winding
  function automatic bit pixel_inside(int x, int y);
    longint px, py;
    bit s_ab, s_bc, s_ca;
    px = longint'(x) * (1 << FRAC_BITS);
    py = longint'(y) * (1 << FRAC_BITS);
    s_ab = edge_negative(px, py, 0, 1);
    s_bc = edge_negative(px, py, 1, 2);
    s_ca = edge_negative(px, py, 2, 0);
    return (s_ab == s_bc) && (s_bc == s_ca);
  endfunction

  function automatic void load_triangle(logic [IN_DATA_W-1:0] data);
    int lo_x, hi_x, lo_y, hi_y;
    for (int i = 0; i < 3; i++) begin
      tri_x[i] = $signed(data[(2 * i) * COORD_W +: COORD_W]);
      tri_y[i] = $signed(data[(2 * i + 1) * COORD_W +: COORD_W]);
    end
    tri_color = data[NUM_COORDS * COORD_W +: COLOR_W];
    lo_x = tri_x[0];
    hi_x = tri_x[0];
    lo_y = tri_y[0];
    hi_y = tri_y[0];
    for (int i = 1; i < 3; i++) begin
      if (tri_x[i] < lo_x) lo_x = tri_x[i];
      if (tri_x[i] > hi_x) hi_x = tri_x[i];
      if (tri_y[i] < lo_y) lo_y = tri_y[i];
      if (tri_y[i] > hi_y) hi_y = tri_y[i];
    end
    box_x0 = toward_zero(lo_x);
    box_x1 = toward_zero(hi_x);
    box_y0 = toward_zero(lo_y);
    box_y1 = toward_zero(hi_y);
    scan_x = box_x0;
    scan_y = box_y0;
    walk_live = 1'b1;
  endfunction

  // Advance the walk (x outer, y inner) to the next covered pixel; an
  // exhausted box or an idle rasterizer answers with an all-zero beat.
  function automatic pixel_t next_covered_pixel();
    pixel_t res;
    int x, y;
    bit hit;
    res = '0;
    while (walk_live && scan_x <= box_x1) begin
      x = scan_x;
      y = scan_y;
      hit = pixel_inside(x, y);
      scan_y++;
      if (scan_y > box_y1) begin
        scan_y = box_y0;
        scan_x++;
      end
      if (hit) begin
        res.found = 1'b1;
        res.px    = x[PIX_W-1:0];
        res.py    = y[PIX_W-1:0];
        res.color = tri_color;
        return res;
      end
    end
    walk_live = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [IN_DATA_W-1:0] pack_triangle(int ax, int ay, int bx, int by,
                                                         int cx, int cy,
                                                         logic [COLOR_W-1:0] color);
    return {color, cy[COORD_W-1:0], cx[COORD_W-1:0], by[COORD_W-1:0],
            bx[COORD_W-1:0], ay[COORD_W-1:0], ax[COORD_W-1:0]};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_bits();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[IN_DATA_W-1:0];
  endfunction

  // Coordinate within span of a center, clamped to the Q12.4 range
  function automatic int near_q(int center, int span);
    int v;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    if (v < MIN_Q) v = MIN_Q;
    if (v > MAX_Q) v = MAX_Q;
    return v;
  endfunction

  // Small triangle anywhere in the coordinate range, so every vertex bit
  // toggles while the box stays a few pixels wide
  function automatic logic [IN_DATA_W-1:0] random_triangle(int span);
    int cx, cy;
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    return pack_triangle(near_q(cx, span), near_q(cy, span), near_q(cx, span),
                         near_q(cy, span), near_q(cx, span), near_q(cy, span),
                         COLOR_W'($urandom));
  endfunction

  task automatic add_row(input logic kind, input logic [IN_DATA_W-1:0] data,
                         input bit typed, input pixel_t want);
    stim_row_t row;
    row.kind  = kind;
    row.data  = data;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Drive one input beat, hold it until accepted, then update the predictor.
  // Valid is dropped only when a gap is taken, so it never toggles twice in
  // one time step.
  task automatic push_request(input logic kind, input logic [IN_DATA_W-1:0] data,
                              input bit typed, input pixel_t want);
    int gap;
    pixel_t predicted;
    gap = (idle_mode != 0 && $urandom_range(0, 3) < idle_mode) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (kind == KIND_START) begin
      load_triangle(data);
      starts_sent++;
    end else begin
      predicted = next_covered_pixel();
      pending_pixels.push_back(typed ? want : predicted);
      fetches_sent++;
    end
  endtask

  task automatic fetch_pixel();
    push_request(KIND_NEXT, random_bits(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random ready bursts, held high whenever idling is off
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (idle_mode == 0) begin
      ready_level = 1'b1;
      ready_left  = 0;
    end else if (ready_left == 0) begin
      if (ready_level && $urandom_range(0, 3) < idle_mode) begin
        ready_level = 1'b0;
        ready_left  = $urandom_range(1, 13);
      end else begin
        ready_level = 1'b1;
        ready_left  = $urandom_range(1, 24);
      end
    end else begin
      ready_left--;
    end
    out_tready <= ready_level;
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[PIX_W-1:0], out_tdata[2*PIX_W-1:PIX_W],
             out_tdata[2*PIX_W +: COLOR_W]};
      if (got.found) hits_seen++;
      else ends_seen++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        report_field("found", 32'(want.found), 32'(got.found));
        report_field("pixel_x", 32'(want.px), 32'(got.px));
        report_field("pixel_y", 32'(want.py), 32'(got.py));
        report_field("pixel_color", 32'(want.color), 32'(got.color));
      end
    end
  end

  // Watchdog: end the run when neither stream moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_pixels.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int pick, cap, fetched, span;

    // Directed table. Rows whose result is plain from the triangle carry
    // it; the others are left to the predictor.
    // fetch before any triangle was loaded
    add_row(KIND_NEXT, random_bits(), 1'b1, '0);
    // three coincident vertices at the most negative corner: the single box
    // pixel sits on every edge, so it is covered
    add_row(KIND_START, pack_triangle(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
                                      24'hFFFFFF), 1'b0, '0);
    add_row(KIND_NEXT, random_bits(), 1'b1, pixel_t'{1'b1, 12'h800, 12'h800, 24'hFFFFFF});
    add_row(KIND_NEXT, random_bits(), 1'b1, '0);   // box exhausted
    add_row(KIND_NEXT, random_bits(), 1'b1, '0);   // walk already finished
    // same at the most positive corner, truncated down to pixel 2047
    add_row(KIND_START, pack_triangle(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q,
                                      24'h000000), 1'b0, '0);
    add_row(KIND_NEXT, random_bits(), 1'b1, pixel_t'{1'b1, 12'h7FF, 12'h7FF, 24'h000000});
    add_row(KIND_NEXT, random_bits(), 1'b1, '0);
    // full-range right triangle: widest products; the first column lies on
    // an edge and counts as covered
    add_row(KIND_START, pack_triangle(MIN_Q, MIN_Q, MAX_Q, MIN_Q, MIN_Q, MAX_Q,
                                      24'hA5A5A5), 1'b0, '0);
    add_row(KIND_NEXT, random_bits(), 1'b0, '0);
    add_row(KIND_NEXT, random_bits(), 1'b0, '0);
    // restart mid-walk with negative fractional vertices (truncation to zero)
    add_row(KIND_START, pack_triangle(-17, -33, 40, -15, -1, 50, 24'h5A5A5A), 1'b0, '0);
    repeat (4) add_row(KIND_NEXT, random_bits(), 1'b0, '0);
    // opposite winding
    add_row(KIND_START, pack_triangle(0, 0, 0, 64, 64, 0, 24'h123456), 1'b0, '0);
    repeat (3) add_row(KIND_NEXT, random_bits(), 1'b0, '0);
    // collinear vertices: only pixels on the line are covered
    add_row(KIND_START, pack_triangle(0, 0, 32, 32, 64, 64, 24'hFEDCBA), 1'b0, '0);
    repeat (3) add_row(KIND_NEXT, random_bits(), 1'b0, '0);

    // hold reset, then release it at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      push_request(directed_rows[i].kind, directed_rows[i].data,
                   directed_rows[i].typed, directed_rows[i].want);

    // Random part: mostly a start followed by fetches until the box is done,
    // with early restarts, extra fetches past the end, stray fetches, and
    // wide-range starts that are replaced before any fetch.
    while (beats_sent < TOTAL_BEATS) begin
      idle_mode = (beats_sent >= TOTAL_BEATS - QUIET_TAIL) ? 0 : $urandom_range(0, 3);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        fetch_pixel();
      end else begin
        if (pick == 1) push_request(KIND_START, random_bits(), 1'b0, '0);
        span = ($urandom_range(0, 15) == 0) ? 160 : 48;
        push_request(KIND_START, random_triangle(span), 1'b0, '0);
        cap = $urandom_range(4, 60);
        fetched = 0;
        while (walk_live && fetched < cap) begin
          fetch_pixel();
          fetched++;
        end
        if (!walk_live && $urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 2)) fetch_pixel();
      end
    end

    // drop valid, wait for every predicted beat, then watch for strays
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d triangle loads and %0d pixel fetches", starts_sent, fetches_sent);
    $display("Result beats checked: %0d covered pixels, %0d end-of-walk", hits_seen, ends_seen);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
